// ===== rtl/core/rlt_pkg.sv =====
// rlt_pkg: request codes and field widths for the resource lock table
// used by resource_lock_table_top; depends on nothing
package rlt_pkg;

    localparam int unsigned REQ_W   = 3;
    localparam int unsigned INDEX_W = 6;
    localparam int unsigned ID_W    = 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_ACQUIRE   = 3'd0,
        REQ_RELEASE   = 3'd1,
        REQ_QUERY     = 3'd2,
        REQ_FORCE     = 3'd3,
        REQ_INTRODUCE = 3'd4
    } t_req_kind;

endpackage

// ===== rtl/core/resource_lock_table_top.sv =====
// resource_lock_table_top: lock table with owner, held, introduced and waiting-for marks
// depends on rlt_pkg for request codes and field widths
//
// channel   direction  handshake                 beat
// request   in         start high, busy low      i_req_type, i_entry_index, i_holder_id
// result    out        o_done for one cycle      o_ok, o_victim_valid, o_victim_holder
//
// one request per cycle; busy is always low
// a result passes the input register, then the table
// update and result register in the same cycle
// synchronous active-low reset clears the table, introduces all entries but the last
// the receiver cannot stall: each result is shown for exactly one cycle
module resource_lock_table_top #(
    parameter int unsigned ENTRIES     = 4,
    parameter int unsigned HOLDER_BITS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [rlt_pkg::REQ_W-1:0]    i_req_type,
    input  logic [rlt_pkg::INDEX_W-1:0]  i_entry_index,
    input  logic [rlt_pkg::ID_W-1:0]     i_holder_id,
    output logic                         o_done,
    output logic                         o_ok,
    output logic                         o_victim_valid,
    output logic [rlt_pkg::ID_W-1:0]     o_victim_holder
);

    localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // input register
    logic                         r_req_valid;
    rlt_pkg::t_req_kind           r_req_type;
    logic [rlt_pkg::INDEX_W-1:0]  r_index;
    logic [rlt_pkg::ID_W-1:0]     r_holder;

    // table state
    logic [HOLDER_BITS-1:0] r_owner [ENTRIES];
    logic [ENTRIES-1:0]     r_held;
    logic [ENTRIES-1:0]     r_intro;
    logic [ENTRIES-1:0]     r_wv;
    logic [IDX_W-1:0]       r_wt [ENTRIES];

    logic [HOLDER_BITS-1:0] n_owner [ENTRIES];
    logic [ENTRIES-1:0]     n_held;
    logic [ENTRIES-1:0]     n_intro;
    logic [ENTRIES-1:0]     n_wv;
    logic [IDX_W-1:0]       n_wt [ENTRIES];

    // result register
    logic                     r_done;
    logic                     r_ok;
    logic                     r_vvalid;
    logic [rlt_pkg::ID_W-1:0] r_vholder;
    logic                     n_ok;
    logic                     n_vvalid;
    logic [rlt_pkg::ID_W-1:0] n_vholder;

    logic                   accept;
    logic                   in_range;
    logic [IDX_W-1:0]       idx;
    logic [HOLDER_BITS-1:0] who;
    logic [HOLDER_BITS-1:0] victim;
    logic [ENTRIES-1:0]     hit;
    logic [ENTRIES-1:0]     vhit;
    logic                   fh_found;
    logic [IDX_W-1:0]       fh_idx;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else begin
            r_req_valid <= accept;
        end
        if (accept) begin
            r_req_type <= rlt_pkg::t_req_kind'(i_req_type);
            r_index    <= i_entry_index;
            r_holder   <= i_holder_id;
        end
    end

    assign in_range = ({1'b0, r_index} < (rlt_pkg::INDEX_W + 1)'(ENTRIES));
    assign idx      = r_index[IDX_W-1:0];
    assign who      = HOLDER_BITS'(r_holder);
    assign victim   = r_owner[idx];

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            hit[i]  = r_held[i] && (r_owner[i] == who);
            vhit[i] = r_held[i] && (r_owner[i] == victim);
        end
        // lowest held entry of the requester
        fh_found = 1'b0;
        fh_idx   = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (hit[i]) begin
                fh_found = 1'b1;
                fh_idx   = IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_owner   = r_owner;
        n_held    = r_held;
        n_intro   = r_intro;
        n_wv      = r_wv;
        n_wt      = r_wt;
        n_ok      = 1'b0;
        n_vvalid  = 1'b0;
        n_vholder = '0;
        if (r_req_valid && in_range) begin
            unique case (r_req_type)
                rlt_pkg::REQ_ACQUIRE: begin
                    if (!r_intro[idx] || r_held[idx]) begin
                        if (fh_found) begin
                            n_wv[fh_idx] = 1'b1;
                            n_wt[fh_idx] = idx;
                        end
                    end else begin
                        n_held[idx]  = 1'b1;
                        n_owner[idx] = who;
                        for (int i = 0; i < ENTRIES; i++) begin
                            if ((IDX_W'(i) != idx) && hit[i]) begin
                                n_wv[i] = 1'b0;
                            end
                        end
                        n_ok = 1'b1;
                    end
                end
                rlt_pkg::REQ_RELEASE: begin
                    if (hit[idx]) begin
                        n_held[idx] = 1'b0;
                        n_wv[idx]   = 1'b0;
                        n_ok        = 1'b1;
                    end
                end
                rlt_pkg::REQ_QUERY: begin
                    n_ok = hit[idx];
                end
                rlt_pkg::REQ_FORCE: begin
                    n_wv[idx] = 1'b0;
                    if (r_held[idx]) begin
                        n_vvalid    = 1'b1;
                        n_vholder   = rlt_pkg::ID_W'(victim);
                        n_ok        = 1'b1;
                        n_held[idx] = 1'b0;
                        for (int i = 0; i < ENTRIES; i++) begin
                            if ((IDX_W'(i) != idx) && vhit[i]) begin
                                n_wv[i] = 1'b0;
                            end
                        end
                    end
                end
                rlt_pkg::REQ_INTRODUCE: begin
                    if (!r_intro[idx]) begin
                        n_intro[idx] = 1'b1;
                        n_ok         = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= '0;
            r_wv    <= '0;
            r_done  <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_owner[i] <= '0;
                r_wt[i]    <= '0;
                r_intro[i] <= (i != ENTRIES - 1);
            end
        end else begin
            r_owner <= n_owner;
            r_held  <= n_held;
            r_intro <= n_intro;
            r_wv    <= n_wv;
            r_wt    <= n_wt;
            r_done  <= r_req_valid;
        end
        r_ok      <= n_ok;
        r_vvalid  <= n_vvalid;
        r_vholder <= n_vholder;
    end

    assign o_done          = r_done;
    assign o_ok            = r_ok;
    assign o_victim_valid  = r_vvalid;
    assign o_victim_holder = r_vholder;

    // a result beat follows every accepted request
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept ##1 i_rst_n |=> o_done)
        else $error("result beat missing after accepted request");

    a_victim_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_victim_valid |-> o_ok)
        else $error("victim reported without ok");

    a_victim_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_victim_valid |-> (o_victim_holder == '0))
        else $error("victim holder not zero without victim");

    a_held_intro: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_held & ~r_intro) == 0)
        else $error("held entry that was never introduced");

    a_wait_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_wv & ~r_held) == 0)
        else $error("waiting mark on a free entry");

endmodule
